/* rtl/ppc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_pkg: shared types and constants of the pixel priority compositor
// Beat formats, opcodes, the token that walks the sprite cell row, and the
// fixed 64-entry RGB color table.
// ----------------------------------------------------------------------------
package ppc_pkg;

  // Default number of sprite slots (cells in the row).
  localparam int SPRITE_SLOTS_DEF = 8;

  // Palette RAM geometry (fixed).
  localparam int PALETTE_ENTRIES = 32;
  localparam int PAL_AW          = 5;

  // Configuration port geometry.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_BG       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_LEFT_BG  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_SPR      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_LEFT_SPR = 2'd3;

  // Opcodes.
  localparam logic [2:0] OP_RENDER      = 3'd0;
  localparam logic [2:0] OP_LOAD_SLOT   = 3'd1;
  localparam logic [2:0] OP_CLEAR_SLOTS = 3'd2;
  localparam logic [2:0] OP_WRITE_PAL   = 3'd3;
  localparam logic [2:0] OP_CLEAR_HIT   = 3'd4;

  // Last screen column, where no sprite-zero hit is flagged.
  localparam logic [7:0] LAST_COLUMN = 8'd255;

  // Input beat.
  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  pixel_x;
    logic [2:0]  fine_scroll_x;
    logic [15:0] bg_pattern_low;
    logic [15:0] bg_pattern_high;
    logic [3:0]  bg_attribute_pair;
    logic [4:0]  target_index;
    logic [7:0]  sprite_left;
    logic [7:0]  sprite_attr;
    logic [7:0]  data_low;
    logic [7:0]  sprite_pattern_high;
    logic        sprite_is_zero;
  } in_beat_t;

  // Result beat.
  typedef struct packed {
    logic [23:0] rgb_color;
    logic [5:0]  color_index;
    logic        sprite_zero_hit;
  } out_beat_t;

  // Configuration register set.
  typedef struct packed {
    logic show_bg;
    logic show_left_bg;
    logic show_spr;
    logic show_left_spr;
  } cfg_t;

  // Work token handed from cell to cell.
  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] pixel_x;
    logic [4:0] target_index;
    logic [7:0] sprite_left;
    logic [7:0] sprite_attr;
    logic [7:0] data_low;
    logic [7:0] pattern_high;
    logic       is_zero;
    logic [3:0] bg_color;    // background palette address, 0 when transparent
    logic       spr_en;      // sprites visible at this column
    logic       found;       // an opaque sprite has been picked
    logic [4:0] spr_color;   // sprite palette address of the picked sprite
    logic       behind;      // picked sprite sits behind the background
    logic       hit_set;     // picked sprite raises sprite-zero hit
  } tok_t;

  // Fixed master color table.
  function automatic logic [23:0] rgb_lookup(input logic [5:0] idx);
    logic [23:0] c;
    case (idx)
      6'd0:  c = 24'h666666;  6'd1:  c = 24'h882A00;
      6'd2:  c = 24'hA71214;  6'd3:  c = 24'hA4003B;
      6'd4:  c = 24'h7E005C;  6'd5:  c = 24'h40006E;
      6'd6:  c = 24'h00066C;  6'd7:  c = 24'h001D56;
      6'd8:  c = 24'h003533;  6'd9:  c = 24'h00480B;
      6'd10: c = 24'h005200;  6'd11: c = 24'h084F00;
      6'd12: c = 24'h4D4000;  6'd13: c = 24'h000000;
      6'd14: c = 24'h000000;  6'd15: c = 24'h000000;
      6'd16: c = 24'hADADAD;  6'd17: c = 24'hD95F15;
      6'd18: c = 24'hFF4042;  6'd19: c = 24'hFE2775;
      6'd20: c = 24'hCC1AA0;  6'd21: c = 24'h7B1EB7;
      6'd22: c = 24'h2031B5;  6'd23: c = 24'h004E99;
      6'd24: c = 24'h006D6B;  6'd25: c = 24'h008738;
      6'd26: c = 24'h00930C;  6'd27: c = 24'h328F00;
      6'd28: c = 24'h8D7C00;  6'd29: c = 24'h000000;
      6'd30: c = 24'h000000;  6'd31: c = 24'h000000;
      6'd32: c = 24'hFFFEFF;  6'd33: c = 24'hFFB064;
      6'd34: c = 24'hFF9092;  6'd35: c = 24'hFF76C6;
      6'd36: c = 24'hFF6AF3;  6'd37: c = 24'hCC6EFE;
      6'd38: c = 24'h7081FE;  6'd39: c = 24'h229EEA;
      6'd40: c = 24'h00BEBC;  6'd41: c = 24'h00D888;
      6'd42: c = 24'h30E45C;  6'd43: c = 24'h82E045;
      6'd44: c = 24'hDECD48;  6'd45: c = 24'h4F4F4F;
      6'd46: c = 24'h000000;  6'd47: c = 24'h000000;
      6'd48: c = 24'hFFFEFF;  6'd49: c = 24'hFFDFC0;
      6'd50: c = 24'hFFD2D3;  6'd51: c = 24'hFFC8E8;
      6'd52: c = 24'hFFC2FB;  6'd53: c = 24'hEAC4FE;
      6'd54: c = 24'hC5CCFE;  6'd55: c = 24'hA5D8F7;
      6'd56: c = 24'h94E5E4;  6'd57: c = 24'h96EFCF;
      6'd58: c = 24'hABF4BD;  6'd59: c = 24'hCCF3B3;
      6'd60: c = 24'hF2EBB5;  6'd61: c = 24'hB8B8B8;
      6'd62: c = 24'h000000;  6'd63: c = 24'h000000;
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

  // Palette mirroring: entries 16, 20, 24 and 28 alias 0, 4, 8 and 12.
  function automatic logic [PAL_AW-1:0] pal_mirror(input logic [PAL_AW-1:0] a);
    logic [PAL_AW-1:0] m;
    m = a;
    if (a[4] && (a[1:0] == 2'b00)) begin
      m[4] = 1'b0;
    end
    return m;
  endfunction

endpackage

/* rtl/ppc_bg_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_bg_stage: background pixel stage
// Registers each input beat as a work token and computes the background
// palette address from the shift words, fine scroll and attribute bits.
// ----------------------------------------------------------------------------
module ppc_bg_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  ppc_pkg::cfg_t    cfg,
  input  logic             in_valid,
  input  ppc_pkg::in_beat_t in_data,
  output logic             in_ready,
  output logic             dn_valid,
  output ppc_pkg::tok_t    dn_tok,
  input  logic             dn_ready
);
  import ppc_pkg::*;

  logic       valid_r;
  tok_t       tok_r;
  tok_t       tok_nxt;
  logic [3:0] shift;
  logic [3:0] bit_sel;
  logic [1:0] bg_pix;
  logic [1:0] bg_pal;
  logic       bg_en;
  logic       left_col;

  assign in_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_tok   = tok_r;

  // Background pixel selection.
  always_comb begin
    left_col = (in_data.pixel_x[7:3] == 5'd0);
    bg_en    = cfg.show_bg && (cfg.show_left_bg || !left_col);
    shift    = {1'b0, in_data.fine_scroll_x} + {1'b0, in_data.pixel_x[2:0]};
    bit_sel  = 4'd15 - shift;
    bg_pix   = {in_data.bg_pattern_high[bit_sel], in_data.bg_pattern_low[bit_sel]};
    bg_pal   = shift[3] ? in_data.bg_attribute_pair[1:0] : in_data.bg_attribute_pair[3:2];

    tok_nxt.opcode       = in_data.opcode;
    tok_nxt.pixel_x      = in_data.pixel_x;
    tok_nxt.target_index = in_data.target_index;
    tok_nxt.sprite_left  = in_data.sprite_left;
    tok_nxt.sprite_attr  = in_data.sprite_attr;
    tok_nxt.data_low     = in_data.data_low;
    tok_nxt.pattern_high = in_data.sprite_pattern_high;
    tok_nxt.is_zero      = in_data.sprite_is_zero;
    tok_nxt.bg_color     = (bg_en && (bg_pix != 2'b00)) ? {bg_pal, bg_pix} : 4'd0;
    tok_nxt.spr_en       = cfg.show_spr && (cfg.show_left_spr || !left_col);
    tok_nxt.found        = 1'b0;
    tok_nxt.spr_color    = 5'd0;
    tok_nxt.behind       = 1'b0;
    tok_nxt.hit_set      = 1'b0;
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      tok_r <= tok_nxt;
    end
  end

endmodule

/* rtl/ppc_sprite_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_sprite_cell: one sprite slot of the cell row
// Holds one sprite slot and a token register. A render token is tested
// against the slot; load and clear tokens update the slot as they leave.
// ----------------------------------------------------------------------------
module ppc_sprite_cell #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  input  ppc_pkg::tok_t up_tok,
  output logic          up_ready,
  output logic          dn_valid,
  output ppc_pkg::tok_t dn_tok,
  input  logic          dn_ready
);
  import ppc_pkg::*;

  logic       valid_r;
  tok_t       tok_r;
  logic       slot_valid_r;
  logic [7:0] slot_x_r;
  logic [7:0] slot_attr_r;
  logic [7:0] slot_lo_r;
  logic [7:0] slot_hi_r;
  logic       slot_zero_r;

  logic [8:0] diff;
  logic       covers;
  logic [2:0] col;
  logic [2:0] bit_sel;
  logic [1:0] pix;
  logic       pick;
  logic       leave;
  logic       load_me;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign leave    = valid_r && dn_ready;
  assign load_me  = (tok_r.opcode == OP_LOAD_SLOT) && (tok_r.target_index == 5'(IDX));

  // Sprite hit test for this slot; the first opaque slot in row order wins.
  always_comb begin
    diff    = {1'b0, tok_r.pixel_x} - {1'b0, slot_x_r};
    covers  = !diff[8] && (diff[7:3] == 5'd0);
    col     = slot_attr_r[6] ? ~diff[2:0] : diff[2:0];
    bit_sel = 3'd7 - col;
    pix     = {slot_hi_r[bit_sel], slot_lo_r[bit_sel]};
    pick    = (tok_r.opcode == OP_RENDER) && tok_r.spr_en && !tok_r.found &&
              slot_valid_r && covers && (pix != 2'b00);

    dn_tok = tok_r;
    if (pick) begin
      dn_tok.found     = 1'b1;
      dn_tok.behind    = slot_attr_r[5];
      dn_tok.spr_color = {1'b1, slot_attr_r[1:0], pix};
      dn_tok.hit_set   = slot_zero_r && (tok_r.bg_color != 4'd0) &&
                         (tok_r.pixel_x != LAST_COLUMN);
    end
  end

  // Token register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      tok_r <= up_tok;
    end
  end

  // Slot occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= 1'b0;
    end else if (leave) begin
      if (load_me) begin
        slot_valid_r <= 1'b1;
      end else if (tok_r.opcode == OP_CLEAR_SLOTS) begin
        slot_valid_r <= 1'b0;
      end
    end
  end

  // Slot contents.
  always_ff @(posedge clk) begin
    if (leave && load_me) begin
      slot_x_r    <= tok_r.sprite_left;
      slot_attr_r <= tok_r.sprite_attr;
      slot_lo_r   <= tok_r.data_low;
      slot_hi_r   <= tok_r.pattern_high;
      slot_zero_r <= tok_r.is_zero;
    end
  end

endmodule

/* rtl/ppc_palette_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_palette_stage: priority, palette and result stage
// Resolves background against sprite priority, keeps the palette RAM and the
// sticky sprite-zero hit flag, and holds the result beat register.
// ----------------------------------------------------------------------------
module ppc_palette_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  input  ppc_pkg::tok_t       up_tok,
  output logic                up_ready,
  output logic                out_valid,
  output ppc_pkg::out_beat_t  out_data,
  input  logic                out_stall
);
  import ppc_pkg::*;

  logic [7:0]        pal_r [PALETTE_ENTRIES];
  logic              hit_r;
  logic              hit_nxt;
  logic              out_valid_r;
  out_beat_t         out_r;
  out_beat_t         out_nxt;
  logic [PAL_AW-1:0] pix_addr;
  logic [PAL_AW-1:0] wr_addr;
  logic [5:0]        cidx;
  logic              take;

  assign up_ready  = !out_valid_r || !out_stall;
  assign take      = up_valid && up_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Priority between background and sprite, then palette and color lookup.
  always_comb begin
    if (up_tok.found && ((up_tok.bg_color == 4'd0) || !up_tok.behind)) begin
      pix_addr = pal_mirror(up_tok.spr_color);
    end else begin
      pix_addr = pal_mirror({1'b0, up_tok.bg_color});
    end
    cidx    = pal_r[pix_addr][5:0];
    wr_addr = pal_mirror(up_tok.target_index);

    hit_nxt = hit_r;
    if (up_tok.opcode == OP_CLEAR_HIT) begin
      hit_nxt = 1'b0;
    end else if ((up_tok.opcode == OP_RENDER) && up_tok.hit_set) begin
      hit_nxt = 1'b1;
    end

    out_nxt.sprite_zero_hit = hit_nxt;
    if (up_tok.opcode == OP_RENDER) begin
      out_nxt.color_index = cidx;
      out_nxt.rgb_color   = rgb_lookup(cidx);
    end else begin
      out_nxt.color_index = 6'd0;
      out_nxt.rgb_color   = 24'd0;
    end
  end

  // Palette RAM, cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
        pal_r[i] <= 8'd0;
      end
    end else if (take && (up_tok.opcode == OP_WRITE_PAL)) begin
      pal_r[wr_addr] <= up_tok.data_low;
    end
  end

  // Sticky hit flag and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        hit_r <= hit_nxt;
      end
      if (up_ready) begin
        out_valid_r <= up_valid;
      end
    end
  end

  // Result beat register.
  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= out_nxt;
    end
  end

endmodule

/* rtl/pixel_priority_compositor_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_priority_compositor_unit: line pixel compositor, top level
// Input beats carry an opcode: render a pixel, load a sprite slot, clear all
// slots, write a palette entry or clear the sprite-zero hit flag. Every input
// beat yields exactly one result beat, in order.
//
// The input channel (in_valid / in_stall / in_data) feeds a background stage,
// then a row of SPRITE_SLOTS sprite cells, one per slot, then the palette and
// result stage. One beat is taken every cycle while the receiver does not
// stall; the background, cell and result registers set the latency. Slot
// state is updated as load and clear beats pass, so renders see exactly the
// loads issued ahead of them. The configuration port (cfg_we / cfg_index /
// cfg_wdata) is to be written by the user only while the unit is idle; the
// unit does not enforce this. Synchronous reset clears the palette RAM, slot
// occupancy, the hit flag and configuration. When the receiver stalls, the
// result register holds and beats keep entering until the row fills up.
// ----------------------------------------------------------------------------
module pixel_priority_compositor_unit #(
  parameter int SPRITE_SLOTS = ppc_pkg::SPRITE_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ppc_pkg::in_beat_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ppc_pkg::out_beat_t                out_data,
  input  logic                              cfg_we,
  input  logic [ppc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ppc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import ppc_pkg::*;

  cfg_t cfg_r;
  logic in_ready;
  logic chain_valid [SPRITE_SLOTS+1];
  logic chain_ready [SPRITE_SLOTS+1];
  tok_t chain_tok   [SPRITE_SLOTS+1];

  assign in_stall = !in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SHOW_BG:       cfg_r.show_bg       <= cfg_wdata[0];
        CFG_SHOW_LEFT_BG:  cfg_r.show_left_bg  <= cfg_wdata[0];
        CFG_SHOW_SPR:      cfg_r.show_spr      <= cfg_wdata[0];
        CFG_SHOW_LEFT_SPR: cfg_r.show_left_spr <= cfg_wdata[0];
        default:           cfg_r               <= cfg_r;
      endcase
    end
  end

  // Background stage.
  ppc_bg_stage u_bg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_ready (in_ready),
    .dn_valid (chain_valid[0]),
    .dn_tok   (chain_tok[0]),
    .dn_ready (chain_ready[0])
  );

  // Row of sprite cells.
  for (genvar k = 0; k < SPRITE_SLOTS; k++) begin : g_cell
    ppc_sprite_cell #(
      .IDX (k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (chain_valid[k]),
      .up_tok   (chain_tok[k]),
      .up_ready (chain_ready[k]),
      .dn_valid (chain_valid[k+1]),
      .dn_tok   (chain_tok[k+1]),
      .dn_ready (chain_ready[k+1])
    );
  end

  // Priority, palette and result stage.
  ppc_palette_stage u_pal (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (chain_valid[SPRITE_SLOTS]),
    .up_tok    (chain_tok[SPRITE_SLOTS]),
    .up_ready  (chain_ready[SPRITE_SLOTS]),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  // An accepted input beat lands in the background stage.
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> chain_valid[0])
    else $error("accepted input beat did not reach the background stage");

  // A beat leaving the row always produces a result beat.
  a_row_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (chain_valid[SPRITE_SLOTS] && chain_ready[SPRITE_SLOTS]) |=> out_valid)
    else $error("beat left the cell row without a result");

  // A clear-hit beat reports the flag as clear.
  a_clear_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (chain_valid[SPRITE_SLOTS] && chain_ready[SPRITE_SLOTS] &&
     (chain_tok[SPRITE_SLOTS].opcode == OP_CLEAR_HIT)) |=> !out_data.sprite_zero_hit)
    else $error("clear-hit beat reported a set hit flag");

  // A render that picked a zero sprite over background reports the hit.
  a_hit_set: assert property (@(posedge clk) disable iff (!rst_n)
    (chain_valid[SPRITE_SLOTS] && chain_ready[SPRITE_SLOTS] &&
     (chain_tok[SPRITE_SLOTS].opcode == OP_RENDER) &&
     chain_tok[SPRITE_SLOTS].hit_set) |=> out_data.sprite_zero_hit)
    else $error("sprite-zero hit was not reported");

endmodule
